>>> design/text_tab_expander_line_splitter_top_macros.svh
// Assertion macros used by the text normalizer RTL.
`ifndef TEXT_TAB_EXPANDER_LINE_SPLITTER_TOP_MACROS_SVH
`define TEXT_TAB_EXPANDER_LINE_SPLITTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clock, reset, ante, cons)
`define ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

>>> design/txtexp_pkg.sv
// Types and character constants for the text normalizer.
`default_nettype none

package txtexp_pkg;

  localparam int CHAR_WIDTH  = 21;
  localparam int FIELD_WIDTH = 16;

  // Result kinds
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_LINE_END = 2'd1;
  localparam logic [1:0] KIND_RESTART  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY  = 2'd3;

  // Control characters of interest
  localparam logic [CHAR_WIDTH-1:0] CH_BEL   = 21'h07;
  localparam logic [CHAR_WIDTH-1:0] CH_BS    = 21'h08;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_LF    = 21'h0A;
  localparam logic [CHAR_WIDTH-1:0] CH_VT    = 21'h0B;
  localparam logic [CHAR_WIDTH-1:0] CH_FF    = 21'h0C;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 21'h20;

  // Tab stops every 8 columns
  localparam logic [3:0] TAB_STOP = 4'd8;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] code_unit;
    logic                  end_of_text;
  } item_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0]  out_char;
    logic [1:0]             kind;
    logic [FIELD_WIDTH-1:0] line_count;
    logic [FIELD_WIDTH-1:0] max_line_length;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

>>> design/text_tab_expander_line_splitter_top.sv
// Text normalizer: tab expansion, control stripping, line and summary markers.
//
// Input channel item_*: one code unit (or an end-of-text mark) per transaction.
// Output channel result_*: characters, line-end, restart and summary markers;
// the last flag closes the results caused by one input transaction.
// An accepted transaction passes through the item register and then, through
// logic, the result register. The item register takes one input per cycle
// while the receiver accepts results; a tab holds it while it emits
// 8 - (column mod 8) spaces, one space per cycle. BEL, BS, VT and FF leave
// with no result.
// A carriage return yields one restart marker and clears all counters; end
// of text yields one summary and clears them too.
// Reset (synchronous, active high) empties both registers and zeroes the
// column, line length, longest line and newline counters.
// When the receiver stalls, the result register holds and the item register
// keeps any transaction that has a result to give, so item_ready drops until
// result_ready returns; item_ready also depends combinationally on result_ready.
`default_nettype none

`include "text_tab_expander_line_splitter_top_macros.svh"

module text_tab_expander_line_splitter_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire txtexp_pkg::item_t   item_data,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output txtexp_pkg::result_t      result_data
);

  import txtexp_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Item register
  logic  a_valid;
  item_t a_item;

  // Tab expansion progress
  logic       tab_active;
  logic [2:0] tab_left;

  // Running state
  logic [2:0]             column_phase;
  logic [COUNT_WIDTH-1:0] line_length;
  logic [COUNT_WIDTH-1:0] longest_line;
  logic [COUNT_WIDTH-1:0] newline_count;

  // Decode
  logic is_eot, is_cr, is_lf, is_drop, is_tab;
  logic [CHAR_WIDTH-1:0] cu;
  logic can_emit, fire, first_fire, a_done;
  logic [3:0] tab_count;
  result_t res;

  logic [COUNT_WIDTH:0]   ll_sum;
  logic [COUNT_WIDTH-1:0] ll_add;
  logic [COUNT_WIDTH:0]   nl_sum;
  logic [COUNT_WIDTH-1:0] nl_inc;
  logic [COUNT_WIDTH-1:0] longest_now;
  logic [31:0]            nl_ext, longest_ext;

  assign cu      = a_item.code_unit;
  assign is_eot  = a_item.end_of_text;
  assign is_cr   = !is_eot && (cu == CH_CR);
  assign is_lf   = !is_eot && (cu == CH_LF);
  assign is_tab  = !is_eot && (cu == CH_TAB);
  assign is_drop = !is_eot &&
                   ((cu == CH_BEL) || (cu == CH_BS) || (cu == CH_VT) || (cu == CH_FF));

  assign tab_count = TAB_STOP - {1'b0, column_phase};

  // Saturating counters
  assign ll_sum = {1'b0, line_length} +
                  (is_tab ? (COUNT_WIDTH+1)'(tab_count) : (COUNT_WIDTH+1)'(1));
  assign ll_add = ll_sum[COUNT_WIDTH] ? COUNT_MAX : ll_sum[COUNT_WIDTH-1:0];
  assign nl_sum = {1'b0, newline_count} + (COUNT_WIDTH+1)'(1);
  assign nl_inc = nl_sum[COUNT_WIDTH] ? COUNT_MAX : nl_sum[COUNT_WIDTH-1:0];
  assign longest_now = (line_length > longest_line) ? line_length : longest_line;
  assign nl_ext      = 32'(nl_inc);
  assign longest_ext = 32'(longest_now);

  // Result formed from the held item and current state
  always_comb begin
    res                 = '0;
    res.last            = 1'b1;
    if (is_eot) begin
      res.kind            = KIND_SUMMARY;
      res.line_count      = nl_ext[FIELD_WIDTH-1:0];
      res.max_line_length = longest_ext[FIELD_WIDTH-1:0];
    end else if (is_cr) begin
      res.kind = KIND_RESTART;
    end else if (is_lf) begin
      res.kind = KIND_LINE_END;
    end else if (is_tab) begin
      res.kind     = KIND_CHAR;
      res.out_char = CH_SPACE;
      res.last     = tab_active ? (tab_left == 3'd1) : (tab_count == 4'd1);
    end else begin
      res.kind     = KIND_CHAR;
      res.out_char = cu;
    end
  end

  assign can_emit   = !result_valid || result_ready;
  assign fire       = a_valid && !is_drop && can_emit;
  assign first_fire = fire && !tab_active;
  assign a_done     = a_valid && (is_drop || (fire && res.last));
  assign item_ready = !a_valid || a_done;

  // Registers and state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      tab_active    <= 1'b0;
      tab_left      <= '0;
      column_phase  <= '0;
      line_length   <= '0;
      longest_line  <= '0;
      newline_count <= '0;
      result_valid  <= 1'b0;
    end else begin
      // item register
      if (item_valid && item_ready) begin
        a_valid <= 1'b1;
        a_item  <= item_data;
      end else if (a_done) begin
        a_valid <= 1'b0;
      end

      // tab space counter
      if (fire && is_tab) begin
        if (!tab_active) begin
          if (tab_count != 4'd1) begin
            tab_active <= 1'b1;
            tab_left   <= 3'(tab_count - 4'd1);
          end
        end else begin
          tab_left <= tab_left - 3'd1;
          if (tab_left == 3'd1) tab_active <= 1'b0;
        end
      end

      // state update once per item that emits a result
      if (first_fire) begin
        if (is_eot || is_cr) begin
          column_phase  <= '0;
          line_length   <= '0;
          longest_line  <= '0;
          newline_count <= '0;
        end else if (is_lf) begin
          longest_line  <= longest_now;
          newline_count <= nl_inc;
          line_length   <= '0;
          column_phase  <= '0;
        end else if (is_tab) begin
          line_length  <= ll_add;
          column_phase <= '0;
        end else begin
          line_length  <= ll_add;
          column_phase <= column_phase + 3'd1;
        end
      end

      // result register
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) result_data <= res;
  end

  // Checks
  `ASSERT_IMPLIES(a_tab_held, clk, rst, tab_active, a_valid && is_tab)
  `ASSERT_IMPLIES(a_tab_left_range, clk, rst, tab_active, tab_left != 3'd0)
  `ASSERT_NEXT(a_restart_clears, clk, rst, fire && is_cr,
               line_length == '0 && newline_count == '0 && column_phase == '0)
  `ASSERT_IMPLIES(a_marker_no_char, clk, rst,
                  result_valid && result_data.kind != KIND_CHAR,
                  result_data.out_char == '0)

endmodule

`default_nettype wire
